>>> rtl/core/bitmap_shape_fill_engine_top_macros.svh
// Assertion macros for the shape fill engine.
`ifndef BITMAP_SHAPE_FILL_ENGINE_TOP_MACROS_SVH
`define BITMAP_SHAPE_FILL_ENGINE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BSFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("bsfe: implication check failed");
`define BSFE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("bsfe: next-cycle check failed");
`else
`define BSFE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BSFE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/bsfe_pkg.sv
package bsfe_pkg;

	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

	localparam int COORD_W   = 6;
	localparam int SIZE_W    = 7;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_W-1:0] CFG_RST = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	localparam logic [1:0] OP_SQUARE = 2'd0;
	localparam logic [1:0] OP_LINE   = 2'd1;
	localparam logic [1:0] OP_TRI    = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] DIR_LU = 2'd0;
	localparam logic [1:0] DIR_LD = 2'd1;
	localparam logic [1:0] DIR_RU = 2'd2;
	localparam logic [1:0] DIR_RD = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [COORD_W-1:0] x_start;
		logic [COORD_W-1:0] y_start;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_end;
		logic [SIZE_W-1:0]  shape_size;
		logic [1:0]         corner_dir;
	} cmd_t;

	typedef struct packed {
		logic out_of_range;
		logic pixel_value;
	} res_t;

	// row operation from sequencer to canvas
	typedef struct packed {
		logic               rd;
		logic               wr;
		logic               clr;
		logic [COORD_W-1:0] col_lo;
		logic [COORD_W-1:0] col_hi;
		logic [COORD_W-1:0] pix_col;
	} row_op_t;

endpackage

>>> rtl/core/bsfe_canvas.sv
module bsfe_canvas #(
	parameter int MAX_WIDTH  = bsfe_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bsfe_pkg::MAX_HEIGHT_DEF,
	localparam int AW = $clog2(MAX_HEIGHT),
	localparam int CAW = $clog2(MAX_WIDTH)
) (
	input  logic              clk,
	input  bsfe_pkg::row_op_t op,
	input  logic [AW-1:0]     rd_addr,
	input  logic [AW-1:0]     wr_addr,
	output logic              pix
);
	import bsfe_pkg::*;

	localparam int CMW = (CAW > COORD_W) ? CAW : COORD_W;

	logic [MAX_WIDTH-1:0] mem_q [MAX_HEIGHT];
	logic [MAX_WIDTH-1:0] rd_q;
	logic [MAX_WIDTH-1:0] mask;
	logic [MAX_WIDTH-1:0] wdata;

	always_comb begin
		for (int i = 0; i < MAX_WIDTH; i++) begin
			mask[i] = (CMW'(i) >= CMW'(op.col_lo)) && (CMW'(i) <= CMW'(op.col_hi));
		end
	end

	// rd_q holds the row read last cycle: the row being written now
	assign wdata = op.clr ? '0 : (rd_q | mask);
	assign pix   = rd_q[CAW'(op.pix_col)];

	always_ff @(posedge clk) begin
		if (op.rd) begin
			rd_q <= mem_q[rd_addr];
		end
		if (op.wr) begin
			mem_q[wr_addr] <= wdata;
		end
	end

endmodule

>>> rtl/core/bsfe_seq.sv
`include "bitmap_shape_fill_engine_top_macros.svh"

module bsfe_seq #(
	parameter int MAX_WIDTH  = bsfe_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bsfe_pkg::MAX_HEIGHT_DEF,
	localparam int AW = $clog2(MAX_HEIGHT)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  bsfe_pkg::cmd_t             cmd,
	input  logic [bsfe_pkg::CFG_W-1:0] cfg_width,
	input  logic [bsfe_pkg::CFG_W-1:0] cfg_height,
	output logic                       done,
	output bsfe_pkg::res_t             result,
	output bsfe_pkg::row_op_t          op,
	output logic [AW-1:0]              rd_addr,
	output logic [AW-1:0]              wr_addr,
	input  logic                       pix
);
	import bsfe_pkg::*;

	localparam int MW_SAT = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
	localparam int MH_SAT = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_RD,
		ST_RDW
	} state_t;

	state_t state_q;

	logic [AW-1:0]      clr_cnt_q;
	logic [1:0]         opc_q;
	logic [COORD_W-1:0] xs_q, ys_q, xe_q, ye_q;
	logic [SIZE_W-1:0]  size_q;
	logic               hdir_q, vdir_q;
	logic [SIZE_W-1:0]  j_q, n_q;
	logic               done_q, oor_q, pixel_q;
	logic               wr_s1;
	logic [AW-1:0]      addr_s1;
	logic [COORD_W-1:0] lo_s1, hi_s1;

	// command check
	logic [CFG_W-1:0] used_w, used_h;
	logic [7:0]       x8, y8, xe8, ye8, s8, w8, uw8, uh8;
	logic             tri_left, tri_down, size_zero;
	logic             sq_err, tri_err, ln_err, rd_err, err;
	logic [COORD_W-1:0] dy_in;

	assign used_w = (cfg_width > CFG_W'(MW_SAT)) ? CFG_W'(MW_SAT) : cfg_width;
	assign used_h = (cfg_height > CFG_W'(MH_SAT)) ? CFG_W'(MH_SAT) : cfg_height;

	assign x8  = {2'b00, cmd.x_start};
	assign y8  = {2'b00, cmd.y_start};
	assign xe8 = {2'b00, cmd.x_end};
	assign ye8 = {2'b00, cmd.y_end};
	assign s8  = {1'b0, cmd.shape_size};
	assign w8  = s8 - 8'd1;
	assign uw8 = {1'b0, used_w};
	assign uh8 = {1'b0, used_h};

	assign size_zero = (cmd.shape_size == '0);
	assign tri_left  = cmd.corner_dir inside {DIR_LU, DIR_LD};
	assign tri_down  = cmd.corner_dir inside {DIR_LD, DIR_RD};

	assign sq_err = size_zero || (x8 + s8 > uw8) || (y8 + s8 > uh8);
	assign tri_err = size_zero || (x8 >= uw8) || (y8 >= uh8)
		|| (tri_left ? (x8 < w8) : (x8 + w8 >= uw8))
		|| (tri_down ? (y8 + w8 >= uh8) : (y8 < w8));
	assign ln_err = (x8 >= uw8) || (xe8 >= uw8) || (y8 >= uh8) || (ye8 >= uh8);
	assign rd_err = (x8 >= uw8) || (y8 >= uh8);

	assign dy_in = (cmd.y_end >= cmd.y_start) ? (cmd.y_end - cmd.y_start)
		: (cmd.y_start - cmd.y_end);

	always_comb begin
		case (cmd.opcode)
			OP_SQUARE: err = sq_err;
			OP_LINE:   err = ln_err;
			OP_TRI:    err = tri_err;
			OP_READ:   err = rd_err;
			default:   err = 1'b1;
		endcase
	end

	// span of the current row
	logic [COORD_W-1:0] j6, dx, dy, m, c, row, lo, hi;
	logic [SIZE_W-1:0]  r, t7;

	assign j6  = j_q[COORD_W-1:0];
	assign dx  = hdir_q ? (xe_q - xs_q) : (xs_q - xe_q);
	assign dy  = vdir_q ? (ye_q - ys_q) : (ys_q - ye_q);
	assign m   = (j6 < dx) ? j6 : dx;
	assign c   = hdir_q ? (xs_q + m) : (xs_q - m);
	assign row = vdir_q ? (ys_q + j6) : (ys_q - j6);
	assign r   = (size_q - 7'd1) - j_q;

	always_comb begin
		lo = xs_q;
		hi = xs_q;
		t7 = '0;
		case (opc_q)
			OP_SQUARE: begin
				t7 = {1'b0, xs_q} + size_q - 7'd1;
				hi = t7[COORD_W-1:0];
			end
			OP_TRI: begin
				if (hdir_q) begin
					t7 = {1'b0, xs_q} + r;
					hi = t7[COORD_W-1:0];
				end else begin
					t7 = {1'b0, xs_q} - r;
					lo = t7[COORD_W-1:0];
				end
			end
			OP_LINE: begin
				if (j6 == dy) begin
					lo = (c < xe_q) ? c : xe_q;
					hi = (c < xe_q) ? xe_q : c;
				end else begin
					lo = c;
					hi = c;
				end
			end
			default: begin
				lo = xs_q;
				hi = xs_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			opc_q     <= OP_SQUARE;
			xs_q      <= '0;
			ys_q      <= '0;
			xe_q      <= '0;
			ye_q      <= '0;
			size_q    <= '0;
			hdir_q    <= 1'b0;
			vdir_q    <= 1'b0;
			j_q       <= '0;
			n_q       <= '0;
			done_q    <= 1'b0;
			oor_q     <= 1'b0;
			pixel_q   <= 1'b0;
			wr_s1     <= 1'b0;
			addr_s1   <= '0;
			lo_s1     <= '0;
			hi_s1     <= '0;
		end else begin
			done_q <= 1'b0;
			wr_s1  <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(MAX_HEIGHT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						opc_q  <= cmd.opcode;
						xs_q   <= cmd.x_start;
						ys_q   <= cmd.y_start;
						xe_q   <= cmd.x_end;
						ye_q   <= cmd.y_end;
						size_q <= cmd.shape_size;
						j_q    <= '0;
						if (err) begin
							done_q  <= 1'b1;
							oor_q   <= 1'b1;
							pixel_q <= 1'b0;
						end else begin
							case (cmd.opcode)
								OP_SQUARE: begin
									hdir_q  <= 1'b1;
									vdir_q  <= 1'b1;
									n_q     <= cmd.shape_size;
									state_q <= ST_RUN;
								end
								OP_LINE: begin
									hdir_q  <= (cmd.x_end >= cmd.x_start);
									vdir_q  <= (cmd.y_end >= cmd.y_start);
									n_q     <= {1'b0, dy_in} + 7'd1;
									state_q <= ST_RUN;
								end
								OP_TRI: begin
									hdir_q  <= !tri_left;
									vdir_q  <= tri_down;
									n_q     <= cmd.shape_size;
									state_q <= ST_RUN;
								end
								default: begin
									state_q <= ST_RD;
								end
							endcase
						end
					end
				end
				ST_RUN: begin
					wr_s1   <= 1'b1;
					addr_s1 <= AW'(row);
					lo_s1   <= lo;
					hi_s1   <= hi;
					j_q     <= j_q + 7'd1;
					if (j_q + 7'd1 == n_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					done_q  <= 1'b1;
					oor_q   <= 1'b0;
					pixel_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				ST_RD: begin
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					done_q  <= 1'b1;
					oor_q   <= 1'b0;
					pixel_q <= pix;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy                = (state_q != ST_IDLE);
	assign done                = done_q;
	assign result.out_of_range = oor_q;
	assign result.pixel_value  = pixel_q;

	assign op.rd      = state_q inside {ST_RUN, ST_RD};
	assign op.wr      = wr_s1 || (state_q == ST_CLEAR);
	assign op.clr     = (state_q == ST_CLEAR);
	assign op.col_lo  = lo_s1;
	assign op.col_hi  = hi_s1;
	assign op.pix_col = xs_q;

	assign rd_addr = (state_q == ST_RUN) ? AW'(row) : AW'(ys_q);
	assign wr_addr = (state_q == ST_CLEAR) ? clr_cnt_q : addr_s1;

	`BSFE_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, state_q == ST_IDLE)
	`BSFE_ASSERT_IMP(a_wr_run, clk, arst_n, wr_s1, state_q == ST_RUN || state_q == ST_DRAIN)
	`BSFE_ASSERT_IMP(a_pix_ok, clk, arst_n, pixel_q, !oor_q)
	`BSFE_ASSERT_NXT(a_go, clk, arst_n, state_q == ST_IDLE && start && !err, state_q != ST_IDLE)

endmodule

>>> rtl/core/bitmap_shape_fill_engine_top.sv
// Channel   Transfer when          Payload
// command   start && !busy         cmd    (bsfe_pkg::cmd_t)
// result    done (one cycle)       result (bsfe_pkg::res_t)
// config    cfg_we                 cfg_idx, cfg_data
//
// Shapes do one row read-modify-write per cycle
// through the canvas memory, read of the next row overlapped with the write.
// A pixel read reads the row in ST_RD and samples it in ST_RDW; a rejected command reports on the next cycle.
// After reset a clear pass zeroes every row of the canvas; busy is high.
// The receiver cannot stall: result is valid only in the done cycle.
module bitmap_shape_fill_engine_top #(
	parameter int MAX_WIDTH  = bsfe_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bsfe_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  bsfe_pkg::cmd_t                 cmd,
	output logic                           done,
	output bsfe_pkg::res_t                 result,
	input  logic                           cfg_we,
	input  logic [bsfe_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bsfe_pkg::CFG_W-1:0]     cfg_data
);
	import bsfe_pkg::*;

	localparam int AW = $clog2(MAX_HEIGHT);

	logic [CFG_W-1:0] width_q, height_q;
	row_op_t          op;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic             pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_RST;
			height_q <= CFG_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	bsfe_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.cfg_width  (width_q),
		.cfg_height (height_q),
		.done       (done),
		.result     (result),
		.op         (op),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.pix        (pix)
	);

	bsfe_canvas #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_canvas (
		.clk     (clk),
		.op      (op),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.pix     (pix)
	);

endmodule
